// ===== rtl/core/llpt_pkg.sv =====
// Shared types and constants for the least-loaded process tracker.
// No dependencies; imported by llpt_scan and least_loaded_process_tracker_unit.
`timescale 1ns / 1ps

package llpt_pkg;

    localparam int LOAD_W   = 48;
    localparam int CELLS_W  = 20;
    localparam int LEVEL_W  = 5;
    localparam int WEIGHT_W = CELLS_W + (1 << LEVEL_W) - 1;   // 51
    localparam int SUM_W    = WEIGHT_W + 1;                   // 52

    localparam logic [LOAD_W-1:0]  LOAD_MAX      = '1;
    localparam logic [CELLS_W-1:0] CELLS_RESET   = 20'd4096;
    localparam logic [LEVEL_W-1:0] MIN_LVL_RESET = 5'd0;

    // configuration register indexes
    localparam logic CFG_CELLS   = 1'b0;
    localparam logic CFG_MIN_LVL = 1'b1;

    typedef enum logic [1:0] {
        ACT_ADD       = 2'd0,
        ACT_CLEAR     = 2'd1,
        ACT_CLEAR_ALL = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    // per-cycle control for the argmin scan
    typedef struct packed {
        logic first;   // first entry of the sweep
        logic vld;     // data on the scan input this cycle
        logic hit;     // entry is the addressed worker
    } t_scan_ctl;

endpackage

// ===== rtl/core/llpt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module llpt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/llpt_scan.sv =====
// Streaming argmin over one load per cycle while i_ctl.vld is set; also captures the addressed load.
// Depends on llpt_pkg.
`timescale 1ns / 1ps

module llpt_scan
    import llpt_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic              i_clk,
    input  t_scan_ctl         i_ctl,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [LOAD_W-1:0] i_load,
    output logic [IDX_W-1:0]  o_min_idx,
    output logic [LOAD_W-1:0] o_hit_load
);

    logic [LOAD_W-1:0] r_best_load;
    logic [IDX_W-1:0]  r_best_idx;
    logic [LOAD_W-1:0] r_hit_load;

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            // strict less-than keeps the lowest index on ties
            if (i_ctl.first || (i_load < r_best_load)) begin
                r_best_load <= i_load;
                r_best_idx  <= i_idx;
            end
            if (i_ctl.hit) begin
                r_hit_load <= i_load;
            end else if (i_ctl.first) begin
                r_hit_load <= '0;
            end
        end
    end

    assign o_min_idx  = r_best_idx;
    assign o_hit_load = r_hit_load;

endmodule

// ===== rtl/core/least_loaded_process_tracker_unit.sv =====
// Top level of the least-loaded process tracker: command FSM, load RAM, scan.
// Depends on llpt_pkg, llpt_ram, llpt_scan.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  ----------------------------------------
// command   in         start & !busy            i_action, i_worker_index, i_tree_level
// result    out        o_done (one cycle)       o_least_loaded_worker, o_worker_load,
//                                               o_bad_request, o_saturated
// config    in         i_cfg_we                 i_cfg_idx, i_cfg_data
//
// busy stays high from the accepting edge to the edge that ends the result
// strobe. That span is set by the argmin sweep, which reads the load RAM
// one entry per cycle through its single read port. Reset (synchronous,
// active low) clears the per-entry valid bits, so every load reads as zero
// at once; no clearing pass.
// The result strobe lasts exactly one cycle and cannot be stalled.

module least_loaded_process_tracker_unit
    import llpt_pkg::*;
#(
    parameter int NUM_WORKERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_action,
    input  logic [3:0]          i_worker_index,
    input  logic [LEVEL_W-1:0]  i_tree_level,
    // result
    output logic                o_done,
    output logic [3:0]          o_least_loaded_worker,
    output logic [LOAD_W-1:0]   o_worker_load,
    output logic                o_bad_request,
    output logic                o_saturated,
    // configuration
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CELLS_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(NUM_WORKERS);
    localparam int XW = (AW > 4) ? AW : 4;   // common width for index compares

    // configuration registers
    logic [CELLS_W-1:0] r_cells;
    logic [LEVEL_W-1:0] r_min_lvl;

    // FSM and latched command
    t_state              r_state, n_state;
    logic [1:0]          r_action;
    logic [3:0]          r_idx;
    logic [WEIGHT_W-1:0] r_weight;
    logic                r_lvl_ok;
    logic [AW-1:0]       r_cnt;

    // valid bit per RAM entry: an entry that is not valid reads as zero
    logic [NUM_WORKERS-1:0] r_valid;
    logic                   r_rd_vbit;

    // scan pipeline
    logic          r_scan_vld;
    logic [AW-1:0] r_scan_idx;

    logic r_bad;
    logic r_sat;

    // datapath wires
    logic [XW-1:0]     w_in_ext;
    logic [XW-1:0]     w_idx_ext;
    logic [AW-1:0]     w_in_addr;
    logic [AW-1:0]     w_addr;
    logic              w_in_range;
    logic              w_accept;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [LOAD_W-1:0] w_ram_q;
    logic [LOAD_W-1:0] w_old;
    logic [SUM_W-1:0]  w_sum;
    logic              w_sum_sat;
    logic [LOAD_W-1:0] w_new;
    logic              w_we;
    logic              w_bad;
    logic              w_clr_one;
    logic              w_clr_all;
    logic [LEVEL_W-1:0] w_shift;
    logic [WEIGHT_W-1:0] w_weight;
    t_scan_ctl         w_scan_ctl;
    logic [AW-1:0]     w_min_idx;
    logic [XW-1:0]     w_min_ext;
    logic [LOAD_W-1:0] w_hit_load;

    assign w_accept   = start && !busy;
    assign w_in_ext   = XW'(i_worker_index);
    assign w_in_addr  = w_in_ext[AW-1:0];
    assign w_idx_ext  = XW'(r_idx);
    assign w_addr     = w_idx_ext[AW-1:0];
    assign w_in_range = (32'(r_idx) < 32'(NUM_WORKERS));

    // weight of an add, formed at accept; shift only meaningful when level >= min
    assign w_shift  = i_tree_level - r_min_lvl;
    assign w_weight = WEIGHT_W'(i_tree_level >= r_min_lvl ? 1'b1 : 1'b0) == '0
                    ? '0 : (WEIGHT_W'(r_cells) << w_shift);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells   <= CELLS_RESET;
            r_min_lvl <= MIN_LVL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CELLS:   r_cells   <= i_cfg_data;
                CFG_MIN_LVL: r_min_lvl <= i_cfg_data[LEVEL_W-1:0];
                default:     r_cells   <= r_cells;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_UPDATE;
            S_UPDATE: n_state = S_SCAN;
            S_SCAN:   if (r_cnt == AW'(NUM_WORKERS - 1)) n_state = S_LAST;
            S_LAST:   n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    // latch the command; the read of the addressed entry goes out at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_idx    <= i_worker_index;
            r_weight <= w_weight;
            r_lvl_ok <= (i_tree_level >= r_min_lvl);
        end
    end

    // RAM read port: addressed entry at accept, then the sweep
    assign w_re    = w_accept || (r_state == S_SCAN);
    assign w_raddr = (r_state == S_SCAN) ? r_cnt : w_in_addr;

    always_ff @(posedge i_clk) begin
        r_rd_vbit <= r_valid[w_raddr];
    end

    assign w_old = r_rd_vbit ? w_ram_q : '0;

    // read-modify-write for an add: exact sum, then saturate
    assign w_sum     = SUM_W'(w_old) + SUM_W'(r_weight);
    assign w_sum_sat = (w_sum >= SUM_W'(LOAD_MAX));
    assign w_new     = w_sum_sat ? LOAD_MAX : w_sum[LOAD_W-1:0];

    always_comb begin
        w_bad     = 1'b0;
        w_we      = 1'b0;
        w_clr_one = 1'b0;
        w_clr_all = 1'b0;
        case (r_action)
            ACT_ADD: begin
                w_bad = !w_in_range || !r_lvl_ok;
                w_we  = !w_bad && (r_state == S_UPDATE);
            end
            ACT_CLEAR: begin
                w_bad     = !w_in_range;
                w_clr_one = w_in_range && (r_state == S_UPDATE);
            end
            ACT_CLEAR_ALL: begin
                w_clr_all = (r_state == S_UPDATE);
            end
            default: begin
                w_bad = 1'b1;
            end
        endcase
    end

    // valid bits stand in for clearing the RAM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_clr_all) begin
            r_valid <= '0;
        end else if (w_clr_one) begin
            r_valid[w_addr] <= 1'b0;
        end else if (w_we) begin
            r_valid[w_addr] <= 1'b1;
        end
    end

    // flags for the result
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_bad <= w_bad;
            r_sat <= (r_action == ACT_ADD) && !w_bad && w_sum_sat;
        end
    end

    // sweep counter and scan-data pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_scan_vld <= 1'b0;
        end else begin
            r_scan_vld <= (r_state == S_SCAN);
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + AW'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx <= r_cnt;
    end

    assign w_scan_ctl.first = (r_scan_idx == '0);
    assign w_scan_ctl.vld   = r_scan_vld;
    assign w_scan_ctl.hit   = w_in_range && (XW'(r_scan_idx) == w_idx_ext);

    llpt_ram #(
        .WIDTH (LOAD_W),
        .DEPTH (NUM_WORKERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_new),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    llpt_scan #(
        .IDX_W (AW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_ctl      (w_scan_ctl),
        .i_idx      (r_scan_idx),
        .i_load     (w_old),
        .o_min_idx  (w_min_idx),
        .o_hit_load (w_hit_load)
    );

    // index reported in four bits
    assign w_min_ext             = XW'(w_min_idx);
    assign o_least_loaded_worker = w_min_ext[3:0];
    assign o_worker_load         = w_hit_load;
    assign o_bad_request         = r_bad;
    assign o_saturated           = r_sat;

endmodule
